/* rtl/core/srt_pkg.sv */
// shared types, widths and status codes for the shred reassembly tracker
package srt_pkg;

  localparam int ID_W    = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SLOT_W  = 6;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 24;

  localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
  localparam logic [1:0] STATUS_COMPLETE   = 2'd1;
  localparam logic [1:0] STATUS_FULL       = 2'd2;
  localparam logic [1:0] STATUS_RANGE      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic used_zero;
    logic hit;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/srt_ctrl.sv */
// controller state machine: lookup scan, record fetch and commit sequencing
module srt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  srt_pkg::stat_t stat,
  output srt_pkg::cmd_t  cmd
);

  srt_pkg::state_t state;
  srt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      srt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          // empty table: nothing to search
          state_next = stat.used_zero ? srt_pkg::ST_COMMIT : srt_pkg::ST_SCAN;
        end
      end
      srt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.hit) begin
          state_next = srt_pkg::ST_FETCH;
        end else if (stat.scan_end) begin
          state_next = srt_pkg::ST_COMMIT;
        end else begin
          state_next = srt_pkg::ST_SCAN;
        end
      end
      srt_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = srt_pkg::ST_COMMIT;
      end
      srt_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = srt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/srt_dp.sv */
// datapath: header registers, id and record memories, update logic, result register
module srt_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_FRAGS     = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  srt_pkg::cmd_t             cmd,
  output srt_pkg::stat_t            stat,
  input  logic [srt_pkg::IN_W-1:0]  in_data,
  input  logic                      m_tready,
  output logic                      m_tvalid,
  output logic [srt_pkg::OUT_W-1:0] m_tdata
);

  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int FW    = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int REC_W = MAX_FRAGS + 3 * srt_pkg::CNT_W + 1;

  // record layout from the lowest bit up: total, needed, count, done, map
  localparam int NEED_LO = srt_pkg::CNT_W;
  localparam int CNT_LO  = 2 * srt_pkg::CNT_W;
  localparam int DONE_B  = 3 * srt_pkg::CNT_W;
  localparam int MAP_LO  = DONE_B + 1;

  logic [srt_pkg::ID_W-1:0]  in_id;
  logic [srt_pkg::IDX_W-1:0] in_idx;
  logic [srt_pkg::CNT_W-1:0] in_total;
  logic [srt_pkg::CNT_W-1:0] in_needed;

  logic [CW-1:0] used;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] cmp_idx;
  logic          cmp_vld;
  logic          hit_q;
  logic [IW-1:0] slot_q;

  logic [srt_pkg::ID_W-1:0] id_mem [TABLE_ENTRIES];
  logic [srt_pkg::ID_W-1:0] id_rd;
  logic [REC_W-1:0]         rec_mem [TABLE_ENTRIES];
  logic [REC_W-1:0]         rec_rd;

  logic                      full;
  logic                      reject;
  logic [IW-1:0]             slot;
  logic [REC_W-1:0]          rec_cur;
  logic [REC_W-1:0]          rec_next;
  logic [srt_pkg::CNT_W-1:0] cur_total;
  logic [srt_pkg::CNT_W-1:0] cur_needed;
  logic [srt_pkg::CNT_W-1:0] cur_count;
  logic                      cur_done;
  logic [MAX_FRAGS-1:0]      cur_map;
  logic [MAX_FRAGS-1:0]      map_next;
  logic [srt_pkg::CNT_W-1:0] count_next;
  logic [srt_pkg::CNT_W-1:0] idx_ext;
  logic [FW-1:0]             bit_sel;
  logic                      range_bad;
  logic                      dup;
  logic                      set_bit;
  logic                      done;
  logic                      first;
  logic [1:0]                status;
  logic [31:0]               slot_wide;
  logic [srt_pkg::OUT_W-1:0] result;

  assign full   = (used == CW'(TABLE_ENTRIES));
  assign reject = !hit_q && full;
  assign slot   = hit_q ? slot_q : used[IW-1:0];

  assign stat.used_zero = (used == '0);
  assign stat.hit       = cmp_vld && (id_rd == in_id);
  assign stat.scan_end  = cmp_vld && (id_rd != in_id) && (CW'(cmp_idx) == used - CW'(1));
  assign stat.out_free  = !m_tvalid || m_tready;

  // a new entry starts from the header counts with an empty map
  assign rec_cur = hit_q ? rec_rd
                         : {{MAX_FRAGS{1'b0}}, 1'b0, {srt_pkg::CNT_W{1'b0}}, in_needed, in_total};

  assign cur_total  = rec_cur[srt_pkg::CNT_W-1:0];
  assign cur_needed = rec_cur[NEED_LO +: srt_pkg::CNT_W];
  assign cur_count  = rec_cur[CNT_LO +: srt_pkg::CNT_W];
  assign cur_done   = rec_cur[DONE_B];
  assign cur_map    = rec_cur[MAP_LO +: MAX_FRAGS];

  assign idx_ext   = srt_pkg::CNT_W'(in_idx);
  assign bit_sel   = in_idx[FW-1:0];
  assign range_bad = (idx_ext >= cur_total) || (idx_ext >= srt_pkg::CNT_W'(MAX_FRAGS));
  assign dup       = !range_bad && cur_map[bit_sel];
  assign set_bit   = !range_bad && !dup;

  assign map_next   = set_bit ? (cur_map | (MAX_FRAGS'(1) << bit_sel)) : cur_map;
  assign count_next = cur_count + srt_pkg::CNT_W'(set_bit);
  assign done       = (count_next >= cur_needed);
  assign first      = done && !cur_done;
  assign rec_next   = {map_next, cur_done | done, count_next, cur_needed, cur_total};

  always_comb begin
    priority if (range_bad) begin
      status = srt_pkg::STATUS_RANGE;
    end else if (done) begin
      status = srt_pkg::STATUS_COMPLETE;
    end else begin
      status = srt_pkg::STATUS_INCOMPLETE;
    end
  end

  assign slot_wide = 32'(slot);

  always_comb begin
    if (reject) begin
      result = {{(srt_pkg::OUT_W - 2){1'b0}}, srt_pkg::STATUS_FULL};
    end else begin
      result = {6'd0, slot_wide[srt_pkg::SLOT_W-1:0], count_next, dup, first, done, status};
    end
  end

  // header capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_id     <= in_data[63:0];
      in_idx    <= in_data[69:64];
      in_total  <= in_data[76:70];
      in_needed <= in_data[83:77];
    end
  end

  // id memory: claimed at commit, read one entry per cycle while scanning
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_q && !full) begin
      id_mem[slot] <= in_id;
    end
    if (cmd.scan && (CW'(scan_idx) < used)) begin
      id_rd <= id_mem[scan_idx];
    end
  end

  // record memory: fetched on a hit, written back at commit
  always_ff @(posedge clk) begin
    if (cmd.commit && !reject) begin
      rec_mem[slot] <= rec_next;
    end
    if (cmd.fetch) begin
      rec_rd <= rec_mem[slot_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= scan_idx;
      if (stat.hit) begin
        slot_q <= cmp_idx;
      end
    end
    if (cmd.commit) begin
      m_tdata <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      hit_q    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        cmp_vld  <= 1'b0;
        hit_q    <= 1'b0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + IW'(1);
        cmp_vld  <= 1'b1;
        if (stat.hit) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd.commit && !hit_q && !full) begin
        used <= used + CW'(1);
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/shred_reassembly_tracker_core.sv */
// top level: fragment header in, per-fragment reassembly status out
// the id scan walks the claimed entries (used) until a hit or the last one; a miss or a
// full-table reject scans them all, and an empty table skips the scan
// throughput: one header in flight; the next is taken once its result beat is registered,
// while that beat may still wait; the scan reads one entry per cycle, output stalls hold commit
// reset: synchronous, clears the entry count and handshake state, not the memories
module shred_reassembly_tracker_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_FRAGS     = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // group_id[63:0], frag_index[69:64], frag_total[76:70], frags_needed[83:77], zero pad
  input  logic [srt_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[1:0], complete[2], first_complete[3], duplicate[4],
  // received_count[11:5], slot[17:12], zero pad
  output logic [srt_pkg::OUT_W-1:0] m_tdata
);

  srt_pkg::cmd_t  cmd;
  srt_pkg::stat_t stat;

  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_FRAGS     (MAX_FRAGS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  // one header at a time: no second beat right after an accepted one
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("header accepted while previous still in work");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == srt_pkg::STATUS_FULL)) |-> (m_tdata[17:2] == '0))
    else $error("rejected header carries nonzero fields");

  a_first_implies_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> m_tdata[2])
    else $error("first completion without completion");

  a_dup_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> (m_tdata[1:0] != srt_pkg::STATUS_RANGE))
    else $error("duplicate flagged on out of range index");
`endif

endmodule
